@@ hdl/rpd_pkg.sv @@
// Package: item types, hash constants, mix selection and controller state codes.
`timescale 1ns / 1ps
`default_nettype none

package rpd_pkg;

    localparam logic [63:0] LANE0_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] LANE1_BASIS = 64'd7809847782465536322;
    localparam logic [63:0] LANE0_PRIME = 64'd1099511628211;
    localparam logic [63:0] LANE1_PRIME = 64'd14029467366897019727;
    localparam logic [63:0] TOKEN_TAG   = 64'h6e696e6665722d74;
    localparam logic [63:0] REWRITE_TAG = 64'h6e696e6665722d72;
    localparam logic [63:0] GOLDEN_XOR  = 64'h9e3779b97f4a7c15;
    localparam int unsigned LANE1_ROT   = 29;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               start_req;
        logic [31:0]        token_id;
        logic [7:0]         token_kind;
        logic signed [31:0] position_a;
        logic signed [31:0] position_b;
        logic signed [31:0] position_c;
        logic               rewrite_mark;
    } t_in_item;

    typedef struct packed {
        logic [63:0] hash_lane_zero;
        logic [63:0] hash_lane_one;
        logic [31:0] frontier_count;
    } t_out_item;

    typedef enum logic [2:0] {
        MIX_TOKEN_TAG,
        MIX_TOKEN_ID,
        MIX_TOKEN_TYPE,
        MIX_POS_A,
        MIX_POS_B,
        MIX_POS_C,
        MIX_REWRITE_TAG,
        MIX_COUNT
    } t_mix_sel;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_FINISH
    } t_rpd_state;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       add;
        logic       emit;
        t_mix_sel   mix_sel;
        logic [2:0] byte_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic mark;
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

@@ hdl/rpd_lane.sv @@
// One hash lane: running FNV-1a-style state with a 64-bit multiply per byte.
`timescale 1ns / 1ps
`default_nettype none

module rpd_lane
    import rpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic        i_restart,
    input  wire logic [63:0] i_basis,
    input  wire logic [63:0] i_prime,
    input  wire logic [63:0] i_value,
    output logic      [63:0] o_hash
);

    logic [63:0] r_hash;
    logic [63:0] r_prod_lo;
    logic [31:0] r_cross_a;
    logic [31:0] r_cross_b;
    logic [63:0] w_shifted;
    logic [63:0] w_x;
    logic [31:0] w_cross;

    assign w_shifted = i_value >> {i_cmd.byte_sel, 3'b000};
    assign w_x       = r_hash ^ {56'd0, w_shifted[7:0]};
    assign w_cross   = r_cross_a + r_cross_b;
    assign o_hash    = (r_hash == 64'd0) ? 64'd1 : r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= i_basis;
        end else if (i_cmd.load) begin
            if (i_restart) begin
                r_hash <= i_basis;
            end
        end else if (i_cmd.add) begin
            r_hash <= r_prod_lo + {w_cross, 32'd0};
        end else if (i_cmd.emit) begin
            r_hash <= o_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_lo <= w_x[31:0] * i_prime[31:0];
            r_cross_a <= 32'(w_x[63:32] * i_prime[31:0]);
            r_cross_b <= 32'(w_x[31:0] * i_prime[63:32]);
        end
    end

endmodule

`default_nettype wire

@@ hdl/rpd_datapath.sv @@
// Datapath: item capture, value selection, both lanes, counter and output register.
`timescale 1ns / 1ps
`default_nettype none

module rpd_datapath
    import rpd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire t_in_item   i_in,
    output t_dp_status      o_status,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_out
);

    t_in_item    r_item;
    logic [31:0] r_count;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [31:0] w_count_base;
    logic [31:0] n_count;
    logic [63:0] w_value;
    logic [63:0] w_value_mixed;
    logic [63:0] w_value_one;
    logic [63:0] w_hash0;
    logic [63:0] w_hash1;
    logic        w_restart;

    assign w_restart    = i_in.start_req;
    assign w_count_base = i_in.start_req ? 32'd0 : r_count;
    assign n_count      = (w_count_base == COUNT_MAX) ? w_count_base : w_count_base + 32'd1;

    always_comb begin
        unique case (i_cmd.mix_sel)
            MIX_TOKEN_TAG:   w_value = TOKEN_TAG;
            MIX_TOKEN_ID:    w_value = {32'd0, r_item.token_id};
            MIX_TOKEN_TYPE:  w_value = {56'd0, r_item.token_kind};
            MIX_POS_A:       w_value = {32'd0, r_item.position_a};
            MIX_POS_B:       w_value = {32'd0, r_item.position_b};
            MIX_POS_C:       w_value = {32'd0, r_item.position_c};
            MIX_REWRITE_TAG: w_value = REWRITE_TAG;
            MIX_COUNT:       w_value = {32'd0, r_count};
            default:         w_value = TOKEN_TAG;
        endcase
    end

    assign w_value_mixed = w_value ^ GOLDEN_XOR;
    assign w_value_one   = {w_value_mixed[63-LANE1_ROT:0], w_value_mixed[63:64-LANE1_ROT]};

    rpd_lane u_lane0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_restart (w_restart),
        .i_basis   (LANE0_BASIS),
        .i_prime   (LANE0_PRIME),
        .i_value   (w_value),
        .o_hash    (w_hash0)
    );

    rpd_lane u_lane1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_restart (w_restart),
        .i_basis   (LANE1_BASIS),
        .i_prime   (LANE1_PRIME),
        .i_value   (w_value_one),
        .o_hash    (w_hash1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 32'd0;
        end else if (i_cmd.load) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.hash_lane_zero <= w_hash0;
            r_out.hash_lane_one  <= w_hash1;
            r_out.frontier_count <= r_count;
        end
    end

    assign o_status.mark     = r_item.rewrite_mark;
    assign o_status.out_busy = r_out_valid && !i_ready;
    assign o_valid           = r_out_valid;
    assign o_out             = r_out;

endmodule

`default_nettype wire

@@ hdl/rpd_ctrl.sv @@
// Controller: sequences mixes and bytes and hands finished items to the output.
`timescale 1ns / 1ps
`default_nettype none

module rpd_ctrl
    import rpd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_rpd_state r_state;
    t_rpd_state n_state;
    t_mix_sel   r_mix;
    t_mix_sel   n_mix;
    logic [2:0] r_byte;
    logic [2:0] n_byte;
    logic       w_last_mix;

    assign w_last_mix = (r_mix == MIX_COUNT) || (r_mix == MIX_POS_C && !i_status.mark);

    always_comb begin
        n_state = r_state;
        n_mix   = r_mix;
        n_byte  = r_byte;
        unique case (r_state)
            ST_IDLE: begin
                n_mix  = MIX_TOKEN_TAG;
                n_byte = 3'd0;
                if (i_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                if (r_byte != 3'd7) begin
                    n_byte  = r_byte + 3'd1;
                    n_state = ST_MUL;
                end else if (w_last_mix) begin
                    n_state = ST_FINISH;
                end else begin
                    n_byte  = 3'd0;
                    n_mix   = t_mix_sel'(r_mix + 3'd1);
                    n_state = ST_MUL;
                end
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = (r_state == ST_IDLE);
        o_cmd.load     = (r_state == ST_IDLE) && i_valid;
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.add      = (r_state == ST_ADD);
        o_cmd.emit     = (r_state == ST_FINISH) && !i_status.out_busy;
        o_cmd.mix_sel  = r_mix;
        o_cmd.byte_sel = r_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mix   <= MIX_TOKEN_TAG;
            r_byte  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_mix   <= n_mix;
            r_byte  <= n_byte;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rolling_prefix_digest_unit.sv @@
// Top level: running dual-lane FNV-1a-style digest over a token stream.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_in  (t_in_item)
//   output   out        o_valid / i_ready    o_out (t_out_item)
//
// One item at a time. Each byte is mixed in each lane as partial products,
// then their sum; an item runs six mixes of eight bytes, eight mixes when
// rewrite_mark is set, after it is accepted and before its result is handed over.
// Reset sets both lanes to their offset bases and the counter to zero.
// The result waits in an output register; a new item is taken while it waits,
// and only the hand-over of the next result stalls on a full output register.
`timescale 1ns / 1ps
`default_nettype none

module rolling_prefix_digest_unit
    import rpd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_in,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    rpd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    rpd_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_in     (i_in),
        .o_status (w_status),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
